// ----- src/osdm_pkg.sv -----
// Package for the OPT stack distance marker core.
// Holds the result status codes, the sequencer states and the cell control struct.
// No dependencies.
package osdm_pkg;

    // Width of the depth fields in a result.
    localparam int DEPTH_W  = 6;
    localparam int STATUS_W = 2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_COLD_MISS  = 2'd0,
        ST_HIT        = 2'd1,
        ST_FULL       = 2'd2,
        ST_RESERVED   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINDP,
        S_UPDATE,
        S_REBUILD,
        S_DONE
    } seq_state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic shift_kv;     // rotate keys and markers by one cell
        logic shift_beta;   // rotate the imbalance entries by one cell
        logic count_phase;  // histogram pass is running
        logic count_first;  // first cycle of the histogram pass
        logic count_en;     // broadcast marker is valid for counting
        logic finalise;     // turn the counts into imbalance entries
    } cell_ctl_t;

endpackage

// ----- src/osdm_cell.sv -----
// One cell of the stack ring: a key, its critical marker and one imbalance entry.
// Depends on osdm_pkg for the control struct.
module osdm_cell
    import osdm_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    parameter int INDEX       = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cell_ctl_t                         ctl,
    input  logic [KEY_BITS-1:0]               in_key,
    input  logic [$clog2(STACK_DEPTH):0]      in_marker,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]  in_beta,
    input  logic [$clog2(STACK_DEPTH):0]      bcast_marker,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]  occ,
    output logic [KEY_BITS-1:0]               out_key,
    output logic [$clog2(STACK_DEPTH):0]      out_marker,
    output logic [$clog2(STACK_DEPTH+1)-1:0]  out_beta
);

    localparam int MW = $clog2(STACK_DEPTH) + 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [KEY_BITS-1:0] key_reg;
    logic [MW-1:0]       marker_reg;
    logic [CW-1:0]       beta_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [CW-1:0]       beta_next;
    logic                hit_le;

    // Histogram step: count broadcast markers not above this cell's index.
    always_comb begin
        hit_le   = ctl.count_en && (bcast_marker <= MW'(INDEX));
        cnt_next = (ctl.count_first ? '0 : cnt_reg) + CW'(hit_le);
    end

    // Imbalance is the count minus the index, clamped at zero.
    always_comb begin
        if (cnt_reg >= CW'(INDEX)) begin
            beta_next = cnt_reg - CW'(INDEX);
        end else begin
            beta_next = '0;
        end
    end

    // Key and marker move one cell towards the head on each rotation step.
    always_ff @(posedge aclk) begin
        if (ctl.shift_kv) begin
            key_reg    <= in_key;
            marker_reg <= in_marker;
        end
        if (ctl.count_phase) begin
            cnt_reg <= cnt_next;
        end
    end

    // Imbalance entry rotates during the search and is rebuilt after an update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= '0;
        end else if (ctl.shift_beta) begin
            beta_reg <= in_beta;
        end else if (ctl.finalise && (CW'(INDEX) < occ)) begin
            beta_reg <= beta_next;
        end
    end

    assign out_key    = key_reg;
    assign out_marker = marker_reg;
    assign out_beta   = beta_reg;

endmodule

// ----- src/opt_stack_distance_marker_core.sv -----
// Top level of the OPT stack distance marker: a ring of cells and its sequencer.
// Depends on osdm_pkg and osdm_cell.
//
//   Channel  Direction  Ports                                              Handshake
//   s_       in         s_access_key                                       s_valid/s_ready
//   m_       out        m_status, m_opt_depth, m_lru_depth, m_critical_z   m_valid/m_ready
//
// An access rotates the ring once to search for the key and read the imbalance
// entries. A hit below the top rotates once more to find the OPT marker, and
// every inserting miss or deep hit rotates a further time to rewrite keys and
// markers while the cells build the histogram, then rebuilds the imbalance.
// A top hit or a full miss goes straight from the search to the final step.
// Reset is synchronous and empties the stack. A new transfer is taken while
// the previous result waits; the result stalls in its last step until the
// output register is free.
module opt_stack_distance_marker_core
    import osdm_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KEY_BITS-1:0] s_access_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [5:0]          m_opt_depth,
    output logic [5:0]          m_lru_depth,
    output logic [5:0]          m_critical_z
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MW = $clog2(STACK_DEPTH) + 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    seq_state_t          state_reg, state_next;
    logic [AW-1:0]       pos_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                found_reg;
    logic [AW-1:0]       d_reg;
    logic [AW-1:0]       z_reg;
    logic [AW-1:0]       p_reg;
    logic                pfound_reg;
    logic                miss_reg;
    logic [CW-1:0]       occ_reg;
    logic [KEY_BITS-1:0] held_reg;
    status_t             res_status_reg;

    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [5:0]          m_opt_depth_reg;
    logic [5:0]          m_lru_depth_reg;
    logic [5:0]          m_critical_z_reg;

    cell_ctl_t           ctl;
    logic [KEY_BITS-1:0] key_w    [STACK_DEPTH];
    logic [MW-1:0]       marker_w [STACK_DEPTH];
    logic [CW-1:0]       beta_w   [STACK_DEPTH];

    logic [KEY_BITS-1:0] tail_key;
    logic [MW-1:0]       tail_marker;
    logic [MW-1:0]       new_marker;
    logic [KEY_BITS-1:0] new_key;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       occ_new;
    logic [CW-1:0]       shift_lim;
    logic                in_range;
    logic                match;
    logic                found_c;
    logic [AW-1:0]       d_c;
    logic                last;
    logic                out_free;

    // Ring of cells; cell 0 is the head and the tail is fed by the sequencer.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        if (i == STACK_DEPTH - 1) begin : g_tail
            osdm_cell #(
                .STACK_DEPTH(STACK_DEPTH), .KEY_BITS(KEY_BITS), .INDEX(i)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
                .in_key(tail_key), .in_marker(tail_marker), .in_beta(beta_w[0]),
                .bcast_marker(new_marker), .occ(occ_reg),
                .out_key(key_w[i]), .out_marker(marker_w[i]), .out_beta(beta_w[i])
            );
        end else begin : g_mid
            osdm_cell #(
                .STACK_DEPTH(STACK_DEPTH), .KEY_BITS(KEY_BITS), .INDEX(i)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
                .in_key(key_w[i+1]), .in_marker(marker_w[i+1]), .in_beta(beta_w[i+1]),
                .bcast_marker(new_marker), .occ(occ_reg),
                .out_key(key_w[i]), .out_marker(marker_w[i]), .out_beta(beta_w[i])
            );
        end
    end

    // Head observations during the search pass.
    always_comb begin
        pos_ext  = CW'(pos_reg);
        in_range = pos_ext < occ_reg;
        match    = in_range && (key_w[0] == key_reg);
        found_c  = found_reg || match;
        d_c      = (match && !found_reg) ? pos_reg : d_reg;
        last     = (pos_reg == AW'(STACK_DEPTH - 1));
        occ_new  = miss_reg ? (occ_reg + CW'(1)) : occ_reg;
        out_free = !m_valid_reg || m_ready;
    end

    // Rewrite of the head entry during the update pass.
    always_comb begin
        if (miss_reg) begin
            if (pos_ext < occ_reg) begin
                new_marker = marker_w[0] + MW'(1);
            end else if (pos_ext == occ_reg) begin
                new_marker = MW'(1);
            end else begin
                new_marker = marker_w[0];
            end
        end else begin
            if (pos_reg == p_reg) begin
                new_marker = MW'(1);
            end else if ((pos_reg != '0) && in_range && (marker_w[0] <= MW'(d_reg))) begin
                new_marker = marker_w[0] + MW'(1);
            end else begin
                new_marker = marker_w[0];
            end
        end
        shift_lim = miss_reg ? occ_reg : CW'(d_reg);
        if (pos_reg == '0) begin
            new_key = key_reg;
        end else if (pos_ext <= shift_lim) begin
            new_key = held_reg;
        end else begin
            new_key = key_w[0];
        end
        tail_key    = (state_reg == S_UPDATE) ? new_key : key_w[0];
        tail_marker = (state_reg == S_UPDATE) ? new_marker : marker_w[0];
    end

    // Sequencer: next state and cell control.
    always_comb begin
        state_next      = state_reg;
        ctl             = '0;
        s_ready         = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                ctl.shift_kv   = 1'b1;
                ctl.shift_beta = 1'b1;
                if (last) begin
                    if (found_c) begin
                        state_next = (d_c == '0) ? S_DONE : S_FINDP;
                    end else if (occ_reg == CW'(STACK_DEPTH)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_FINDP: begin
                ctl.shift_kv = 1'b1;
                if (last) state_next = S_UPDATE;
            end
            S_UPDATE: begin
                ctl.shift_kv    = 1'b1;
                ctl.count_phase = 1'b1;
                ctl.count_first = (pos_reg == '0);
                ctl.count_en    = (pos_reg != '0) && (pos_ext < occ_new);
                if (last) state_next = S_REBUILD;
            end
            S_REBUILD: begin
                ctl.finalise = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State, position counter and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_SCAN) || (state_reg == S_FINDP) || (state_reg == S_UPDATE)) begin
                pos_reg <= last ? '0 : (pos_reg + AW'(1));
            end
            if ((state_reg == S_UPDATE) && last) begin
                occ_reg <= occ_new;
            end
        end
    end

    // Per-access working registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            key_reg    <= s_access_key;
            found_reg  <= 1'b0;
            d_reg      <= '0;
            z_reg      <= '0;
            p_reg      <= '0;
            pfound_reg <= 1'b0;
        end
        if (state_reg == S_SCAN) begin
            found_reg <= found_c;
            d_reg     <= d_c;
            if (!found_c && (beta_w[0] == '0)) z_reg <= pos_reg;
            if (last) begin
                miss_reg <= !found_c;
                if (found_c) begin
                    res_status_reg <= ST_HIT;
                end else if (occ_reg == CW'(STACK_DEPTH)) begin
                    res_status_reg <= ST_FULL;
                end else begin
                    res_status_reg <= ST_COLD_MISS;
                end
                p_reg <= d_c;
            end
        end
        // First marker above z, searched from position one.
        if (state_reg == S_FINDP) begin
            if (!pfound_reg && (pos_reg != '0) && in_range && (marker_w[0] > MW'(z_reg))) begin
                p_reg      <= pos_reg;
                pfound_reg <= 1'b1;
            end
        end
        if (state_reg == S_UPDATE) begin
            held_reg <= key_w[0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) m_valid_reg <= 1'b0;
            if ((state_reg == S_DONE) && out_free) m_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_status_reg     <= res_status_reg;
            m_opt_depth_reg  <= DEPTH_W'(p_reg);
            m_lru_depth_reg  <= DEPTH_W'(d_reg);
            m_critical_z_reg <= (res_status_reg == ST_HIT) ? DEPTH_W'(z_reg) : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_opt_depth  = m_opt_depth_reg;
    assign m_lru_depth  = m_lru_depth_reg;
    assign m_critical_z = m_critical_z_reg;

`ifndef NO_ASSERTIONS
    // Occupancy never passes the stack depth.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(STACK_DEPTH))
        else $error("occupancy above stack depth");

    // A new result only appears out of the final step.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside final step");

    // A full report only with a full stack.
    a_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_FULL) |-> occ_reg == CW'(STACK_DEPTH))
        else $error("full reported on a stack with room");

    // Misses carry zero depths.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_HIT)
            |-> (m_opt_depth_reg == '0) && (m_lru_depth_reg == '0)
                && (m_critical_z_reg == '0))
        else $error("miss with non-zero depth");
`endif

endmodule
